@@ design/ctsf_pkg.sv @@
// ----------------------------------------------------------------------------
// ctsf_pkg
// Shared types and codes of the connection table sequence filter.
// ----------------------------------------------------------------------------
package ctsf_pkg;

   // request actions
   localparam logic [1:0] ACT_PACKET = 2'd0;
   localparam logic [1:0] ACT_FIND   = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   // response status codes
   localparam logic [2:0] ST_ACCEPTED = 3'd0;
   localparam logic [2:0] ST_STALE    = 3'd1;
   localparam logic [2:0] ST_TIMEDOUT = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_REMOVED  = 3'd4;
   localparam logic [2:0] ST_BADINDEX = 3'd5;
   localparam logic [2:0] ST_FOUND    = 3'd6;
   localparam logic [2:0] ST_NONE     = 3'd7;

   // configuration register indexes
   localparam logic REG_MAX_CLIENTS = 1'b0;
   localparam logic REG_TIMEOUT_MS  = 1'b1;

   localparam logic [5:0]  MAX_CLIENTS_RESET = 6'd32;
   localparam logic [31:0] TIMEOUT_MS_RESET  = 32'd10000;

   // one table entry as stored in the entry memory
   typedef struct packed {
      logic [31:0] ip;
      logic [15:0] port;
      logic [15:0] qport;
      logic [30:0] last_seq;
      logic        ack_bit;
      logic [31:0] last_time;
   } entry_type;

endpackage

@@ design/connection_table_sequence_filter_core.sv @@
// ----------------------------------------------------------------------------
// connection_table_sequence_filter_core
// Connection table with per-channel sequence filter and timeout tracking.
// ----------------------------------------------------------------------------
// Sequence: packet and find requests scan the table one entry per cycle through
//   the entry memory read port until a hit or the end of the used entries.
//   Remove copies the last entry into the freed slot before it responds.
// Throughput: one request at a time; a new request is taken once the previous
//   response is registered.
// Reset: table empty, max_clients 32, timeout_ms 10000; memory not cleared.
module connection_table_sequence_filter_core #(
   parameter int CHANNELS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   // requests
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_source_ip,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_qport,
   input  logic [30:0] req_packet_seq,
   input  logic        req_packet_rel,
   input  logic [31:0] req_now_ms,
   input  logic [4:0]  req_remove_index,
   // responses
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_channel_index,
   output logic        rsp_is_new,
   output logic        rsp_remote_ack,
   output logic [15:0] rsp_remote_port,
   output logic [5:0]  rsp_channel_count
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(CHANNELS + 1);
   localparam int CW    = (CNT_W > 5) ? CNT_W : 5;
   localparam int LW    = (CNT_W > 6) ? CNT_W : 6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_PKT,
      S_RM_FIRST,
      S_RM_LAST,
      S_EMIT
   } state_type;

   state_type state_ff;

   logic [5:0]       max_clients_ff;
   logic [31:0]      timeout_ms_ff;
   logic [CNT_W-1:0] used_count_ff;

   // latched request
   logic [1:0]       act_ff;
   logic [31:0]      ip_ff;
   logic [15:0]      port_ff;
   logic [15:0]      qport_ff;
   logic [30:0]      seq_ff;
   logic             rel_ff;
   logic [31:0]      now_ff;
   logic [IDX_W-1:0] rmi_ff;

   // scan control
   logic [CNT_W-1:0] scan_ff;
   logic             chk_ff;
   logic [IDX_W-1:0] chk_idx_ff;
   logic             found_ff;

   // pending result
   logic [2:0]       res_status_ff;
   logic [4:0]       res_index_ff;
   logic             res_new_ff;
   logic             res_ack_ff;
   logic [15:0]      res_port_ff;

   logic             rsp_valid_ff;
   logic [2:0]       rsp_status_ff;
   logic [4:0]       rsp_index_ff;
   logic             rsp_new_ff;
   logic             rsp_ack_ff;
   logic [15:0]      rsp_port_ff;
   logic [5:0]       rsp_count_ff;

   // memory ports
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   ctsf_pkg::entry_type rd_data;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   ctsf_pkg::entry_type wr_data;

   ctsf_entry_ram #(
      .DEPTH (CHANNELS),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   logic             req_fire;
   logic             rm_bad;
   logic             timed_out;
   logic             stale_seq;
   logic             key_hit;
   logic             hit;
   logic             scan_more;
   logic             table_full;
   logic [CNT_W-1:0] last_count;
   logic             new_ack;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign rm_bad     = CW'(req_remove_index) >= CW'(used_count_ff);
   assign timed_out  = (now_ff - rd_data.last_time) > timeout_ms_ff;
   assign stale_seq  = seq_ff <= rd_data.last_seq;
   assign key_hit    = (rd_data.ip == ip_ff) && (rd_data.qport == qport_ff);
   assign hit        = chk_ff && ((act_ff == ctsf_pkg::ACT_PACKET) ? key_hit : timed_out);
   assign scan_more  = scan_ff < used_count_ff;
   assign table_full = (LW'(used_count_ff) >= LW'(max_clients_ff))
                       || (used_count_ff == CNT_W'(CHANNELS));
   assign last_count = used_count_ff - CNT_W'(1);
   assign new_ack    = rd_data.ack_bit ^ rel_ff;

   // memory access control; reads and writes never share a cycle
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = scan_ff[IDX_W-1:0];
      wr_en   = 1'b0;
      wr_addr = chk_idx_ff;
      wr_data = rd_data;
      case (state_ff)
         S_IDLE: begin
            rd_addr = IDX_W'(req_remove_index);
            rd_en   = req_fire && (req_action == ctsf_pkg::ACT_REMOVE) && !rm_bad;
         end
         S_SCAN: begin
            rd_en = !hit && scan_more;
         end
         S_PKT: begin
            if (found_ff) begin
               wr_addr           = chk_idx_ff;
               wr_data.last_seq  = seq_ff;
               wr_data.ack_bit   = new_ack;
               wr_data.last_time = now_ff;
               wr_en             = !timed_out && !stale_seq;
            end else begin
               wr_addr           = used_count_ff[IDX_W-1:0];
               wr_data.ip        = ip_ff;
               wr_data.port      = port_ff;
               wr_data.qport     = qport_ff;
               wr_data.last_seq  = seq_ff;
               wr_data.ack_bit   = rel_ff && (seq_ff != '0);
               wr_data.last_time = now_ff;
               wr_en             = !table_full;
            end
         end
         S_RM_FIRST: begin
            rd_addr = last_count[IDX_W-1:0];
            rd_en   = 1'b1;
         end
         S_RM_LAST: begin
            wr_addr = rmi_ff;
            wr_en   = 1'b1;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         max_clients_ff <= ctsf_pkg::MAX_CLIENTS_RESET;
         timeout_ms_ff  <= ctsf_pkg::TIMEOUT_MS_RESET;
         used_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         chk_ff         <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ctsf_pkg::REG_MAX_CLIENTS: max_clients_ff <= csr_data[5:0];
               ctsf_pkg::REG_TIMEOUT_MS:  timeout_ms_ff  <= csr_data;
               default:                   timeout_ms_ff  <= timeout_ms_ff;
            endcase
         end

         // emit refills the response register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  act_ff        <= req_action;
                  ip_ff         <= req_source_ip;
                  port_ff       <= req_source_port;
                  qport_ff      <= req_qport;
                  seq_ff        <= req_packet_seq;
                  rel_ff        <= req_packet_rel;
                  now_ff        <= req_now_ms;
                  rmi_ff        <= IDX_W'(req_remove_index);
                  scan_ff       <= '0;
                  chk_ff        <= 1'b0;
                  res_index_ff  <= '0;
                  res_new_ff    <= 1'b0;
                  res_ack_ff    <= 1'b0;
                  res_port_ff   <= '0;
                  res_status_ff <= ctsf_pkg::ST_NONE;
                  case (req_action)
                     ctsf_pkg::ACT_PACKET, ctsf_pkg::ACT_FIND: begin
                        state_ff <= S_SCAN;
                     end
                     ctsf_pkg::ACT_REMOVE: begin
                        if (rm_bad) begin
                           res_status_ff <= ctsf_pkg::ST_BADINDEX;
                           state_ff      <= S_EMIT;
                        end else begin
                           state_ff <= S_RM_FIRST;
                        end
                     end
                     default: begin
                        state_ff <= S_EMIT;
                     end
                  endcase
               end
            end

            S_SCAN: begin
               if (hit) begin
                  chk_ff <= 1'b0;
                  if (act_ff == ctsf_pkg::ACT_PACKET) begin
                     found_ff <= 1'b1;
                     state_ff <= S_PKT;
                  end else begin
                     res_status_ff <= ctsf_pkg::ST_FOUND;
                     res_index_ff  <= 5'(chk_idx_ff);
                     res_ack_ff    <= rd_data.ack_bit;
                     res_port_ff   <= rd_data.port;
                     state_ff      <= S_EMIT;
                  end
               end else if (scan_more) begin
                  // advance: check this entry next cycle
                  chk_ff     <= 1'b1;
                  chk_idx_ff <= scan_ff[IDX_W-1:0];
                  scan_ff    <= scan_ff + CNT_W'(1);
               end else begin
                  chk_ff <= 1'b0;
                  if (act_ff == ctsf_pkg::ACT_PACKET) begin
                     found_ff <= 1'b0;
                     state_ff <= S_PKT;
                  end else begin
                     res_status_ff <= ctsf_pkg::ST_NONE;
                     state_ff      <= S_EMIT;
                  end
               end
            end

            S_PKT: begin
               state_ff <= S_EMIT;
               if (found_ff) begin
                  res_index_ff <= 5'(chk_idx_ff);
                  res_new_ff   <= 1'b0;
                  res_port_ff  <= rd_data.port;
                  if (timed_out) begin
                     res_status_ff <= ctsf_pkg::ST_TIMEDOUT;
                     res_ack_ff    <= rd_data.ack_bit;
                  end else if (stale_seq) begin
                     res_status_ff <= ctsf_pkg::ST_STALE;
                     res_ack_ff    <= rd_data.ack_bit;
                  end else begin
                     res_status_ff <= ctsf_pkg::ST_ACCEPTED;
                     res_ack_ff    <= new_ack;
                  end
               end else if (table_full) begin
                  res_status_ff <= ctsf_pkg::ST_FULL;
               end else begin
                  // new channel; a zero sequence is stale against the fresh entry
                  used_count_ff <= used_count_ff + CNT_W'(1);
                  res_index_ff  <= 5'(used_count_ff);
                  res_new_ff    <= 1'b1;
                  res_port_ff   <= port_ff;
                  if (seq_ff == '0) begin
                     res_status_ff <= ctsf_pkg::ST_STALE;
                     res_ack_ff    <= 1'b0;
                  end else begin
                     res_status_ff <= ctsf_pkg::ST_ACCEPTED;
                     res_ack_ff    <= rel_ff;
                  end
               end
            end

            S_RM_FIRST: begin
               res_ack_ff  <= rd_data.ack_bit;
               res_port_ff <= rd_data.port;
               state_ff    <= S_RM_LAST;
            end

            S_RM_LAST: begin
               // move the last entry into the freed slot
               used_count_ff <= last_count;
               res_status_ff <= ctsf_pkg::ST_REMOVED;
               res_index_ff  <= 5'(rmi_ff);
               state_ff      <= S_EMIT;
            end

            S_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_index_ff  <= res_index_ff;
                  rsp_new_ff    <= res_new_ff;
                  rsp_ack_ff    <= res_ack_ff;
                  rsp_port_ff   <= res_port_ff;
                  rsp_count_ff  <= 6'(used_count_ff);
                  state_ff      <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_channel_index = rsp_index_ff;
   assign rsp_is_new        = rsp_new_ff;
   assign rsp_remote_ack    = rsp_ack_ff;
   assign rsp_remote_port   = rsp_port_ff;
   assign rsp_channel_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      used_count_ff <= CNT_W'(CHANNELS))
      else $error("channel count exceeds table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(used_count_ff) |->
         (used_count_ff == $past(used_count_ff) + CNT_W'(1)) ||
         (used_count_ff == $past(used_count_ff) - CNT_W'(1)))
      else $error("channel count changed by more than one");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("entry memory read and write in the same cycle");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("response raised outside emit state");

endmodule

@@ design/ctsf_entry_ram.sv @@
// ----------------------------------------------------------------------------
// ctsf_entry_ram
// Channel entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ctsf_entry_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output ctsf_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  ctsf_pkg::entry_type wr_data
);

   ctsf_pkg::entry_type mem [DEPTH];
   ctsf_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Connection table sequence filter testbench
// Drives packet, find, remove and unknown requests through the request port
// under several max_clients and timeout_ms settings. A scoreboard keeps its own
// copy of the channel table, predicts each response and checks every field.
// ----------------------------------------------------------------------------
module testbench;

   localparam int          TABLE_SLOTS    = 32;
   localparam int          POOL_KEYS      = 40;
   localparam int          DRAIN_CYCLES   = TABLE_SLOTS + 8;
   localparam int          HOLD_CYCLES    = 400;
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam logic [1:0]  ACT_UNKNOWN    = 2'd3;

   typedef struct {
      logic [1:0]  action;
      logic [31:0] source_ip;
      logic [15:0] source_port;
      logic [15:0] qport;
      logic [30:0] packet_seq;
      logic        packet_rel;
      logic [31:0] now_ms;
      logic [4:0]  remove_index;
   } conn_request_type;

   typedef struct {
      logic [2:0]  status;
      logic [4:0]  channel_index;
      logic        is_new;
      logic        remote_ack;
      logic [15:0] remote_port;
      logic [5:0]  channel_count;
   } conn_response_type;

   class conn_table_scoreboard;
      logic [31:0]       slot_ip[TABLE_SLOTS];
      logic [15:0]       slot_port[TABLE_SLOTS];
      logic [15:0]       slot_qport[TABLE_SLOTS];
      logic [30:0]       slot_seq[TABLE_SLOTS];
      logic              slot_ack[TABLE_SLOTS];
      logic [31:0]       slot_time[TABLE_SLOTS];
      int                used;
      logic [5:0]        max_clients;
      logic [31:0]       timeout_ms;
      conn_response_type expected[$];
      int                failures;

      function new();
         used        = 0;
         max_clients = ctsf_pkg::MAX_CLIENTS_RESET;
         timeout_ms  = ctsf_pkg::TIMEOUT_MS_RESET;
         failures    = 0;
      endfunction

      function void apply_register(logic index, logic [31:0] data);
         if (index == ctsf_pkg::REG_MAX_CLIENTS)
            max_clients = data[5:0];
         else
            timeout_ms = data;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      // Work out the response to an accepted request and advance the table.
      function void note_request(conn_request_type r);
         conn_response_type e;
         int                slot;
         int                cap;
         int                i;
         bit                hit;
         bit                full;
         logic [31:0]       age;
         e.status        = ctsf_pkg::ST_NONE;
         e.channel_index = '0;
         e.is_new        = 1'b0;
         e.remote_ack    = 1'b0;
         e.remote_port   = '0;
         case (r.action)
            ctsf_pkg::ACT_PACKET: begin
               hit  = 1'b0;
               full = 1'b0;
               slot = 0;
               for (i = 0; i < used; i++) begin
                  if (!hit && slot_ip[i] == r.source_ip && slot_qport[i] == r.qport) begin
                     hit  = 1'b1;
                     slot = i;
                  end
               end
               if (!hit) begin
                  cap = (max_clients < TABLE_SLOTS) ? int'(max_clients) : TABLE_SLOTS;
                  if (used >= cap) begin
                     full     = 1'b1;
                     e.status = ctsf_pkg::ST_FULL;
                  end else begin
                     slot             = used;
                     slot_ip[slot]    = r.source_ip;
                     slot_port[slot]  = r.source_port;
                     slot_qport[slot] = r.qport;
                     slot_seq[slot]   = '0;
                     slot_ack[slot]   = 1'b0;
                     slot_time[slot]  = r.now_ms;
                     used++;
                     e.is_new = 1'b1;
                  end
               end
               if (!full) begin
                  age = r.now_ms - slot_time[slot];
                  if (age > timeout_ms) begin
                     e.status = ctsf_pkg::ST_TIMEDOUT;
                  end else if (r.packet_seq <= slot_seq[slot]) begin
                     e.status = ctsf_pkg::ST_STALE;
                  end else begin
                     if (r.packet_rel)
                        slot_ack[slot] = ~slot_ack[slot];
                     slot_seq[slot]  = r.packet_seq;
                     slot_time[slot] = r.now_ms;
                     e.status        = ctsf_pkg::ST_ACCEPTED;
                  end
                  e.channel_index = slot[4:0];
                  e.remote_ack    = slot_ack[slot];
                  e.remote_port   = slot_port[slot];
               end
            end
            ctsf_pkg::ACT_FIND: begin
               hit = 1'b0;
               for (i = 0; i < used; i++) begin
                  age = r.now_ms - slot_time[i];
                  if (!hit && age > timeout_ms) begin
                     hit             = 1'b1;
                     e.status        = ctsf_pkg::ST_FOUND;
                     e.channel_index = i[4:0];
                     e.remote_ack    = slot_ack[i];
                     e.remote_port   = slot_port[i];
                  end
               end
            end
            ctsf_pkg::ACT_REMOVE: begin
               slot = int'(r.remove_index);
               if (slot >= used) begin
                  e.status = ctsf_pkg::ST_BADINDEX;
               end else begin
                  e.status        = ctsf_pkg::ST_REMOVED;
                  e.channel_index = r.remove_index;
                  e.remote_ack    = slot_ack[slot];
                  e.remote_port   = slot_port[slot];
                  // move the last entry into the freed slot
                  used--;
                  slot_ip[slot]    = slot_ip[used];
                  slot_port[slot]  = slot_port[used];
                  slot_qport[slot] = slot_qport[used];
                  slot_seq[slot]   = slot_seq[used];
                  slot_ack[slot]   = slot_ack[used];
                  slot_time[slot]  = slot_time[used];
               end
            end
            default: ;
         endcase
         e.channel_count = used[5:0];
         expected.push_back(e);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(conn_response_type got);
         conn_response_type want;
         if (expected.size() == 0) begin
            $error("response with status %0d arrived with no request pending", got.status);
            failures++;
         end else begin
            want = expected.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("channel_index", 32'(want.channel_index), 32'(got.channel_index));
            check_field("is_new", 32'(want.is_new), 32'(got.is_new));
            check_field("remote_ack", 32'(want.remote_ack), 32'(got.remote_ack));
            check_field("remote_port", 32'(want.remote_port), 32'(got.remote_port));
            check_field("channel_count", 32'(want.channel_count), 32'(got.channel_count));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_data;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_action;
   logic [31:0] req_source_ip;
   logic [15:0] req_source_port;
   logic [15:0] req_qport;
   logic [30:0] req_packet_seq;
   logic        req_packet_rel;
   logic [31:0] req_now_ms;
   logic [4:0]  req_remove_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [4:0]  rsp_channel_index;
   logic        rsp_is_new;
   logic        rsp_remote_ack;
   logic [15:0] rsp_remote_port;
   logic [5:0]  rsp_channel_count;

   conn_table_scoreboard sb = new();

   int          idle_cycles = 0;
   int          sent_count  = 0;
   bit          calm        = 1'b0;
   bit          squeeze     = 1'b0;
   logic [31:0] wall_ms;
   logic [31:0] pool_ip[POOL_KEYS];
   logic [15:0] pool_qport[POOL_KEYS];
   logic [30:0] pool_seq[POOL_KEYS];

   connection_table_sequence_filter_core #(
      .CHANNELS(TABLE_SLOTS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_source_ip    (req_source_ip),
      .req_source_port  (req_source_port),
      .req_qport        (req_qport),
      .req_packet_seq   (req_packet_seq),
      .req_packet_rel   (req_packet_rel),
      .req_now_ms       (req_now_ms),
      .req_remove_index (req_remove_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_channel_index(rsp_channel_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_remote_ack   (rsp_remote_ack),
      .rsp_remote_port  (rsp_remote_port),
      .rsp_channel_count(rsp_channel_count)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Sample every handshake at the edge and feed the scoreboard.
   always @(posedge clock) begin : monitor
      conn_request_type  seen_req;
      conn_response_type seen_rsp;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen_rsp.status        = rsp_status;
            seen_rsp.channel_index = rsp_channel_index;
            seen_rsp.is_new        = rsp_is_new;
            seen_rsp.remote_ack    = rsp_remote_ack;
            seen_rsp.remote_port   = rsp_remote_port;
            seen_rsp.channel_count = rsp_channel_count;
            sb.check_response(seen_rsp);
         end
         if (req_valid && req_ready) begin
            seen_req.action       = req_action;
            seen_req.source_ip    = req_source_ip;
            seen_req.source_port  = req_source_port;
            seen_req.qport        = req_qport;
            seen_req.packet_seq   = req_packet_seq;
            seen_req.packet_rel   = req_packet_rel;
            seen_req.now_ms       = req_now_ms;
            seen_req.remove_index = req_remove_index;
            sb.note_request(seen_req);
         end
         if (csr_valid && csr_ready)
            sb.apply_register(csr_index, csr_data);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // Response side: random stalls, a calm stretch, and long hold-offs on demand.
   initial begin : receiver
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (squeeze) begin
            squeeze = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= calm || ($urandom_range(99) >= 12);
      end
   end

   task automatic write_register(input logic index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_request(input conn_request_type r);
      int gap;
      gap = (calm || $urandom_range(99) >= 12) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= r.action;
      req_source_ip    <= r.source_ip;
      req_source_port  <= r.source_port;
      req_qport        <= r.qport;
      req_packet_seq   <= r.packet_seq;
      req_packet_rel   <= r.packet_rel;
      req_now_ms       <= r.now_ms;
      req_remove_index <= r.remove_index;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
      calm = (sent_count >= 500 && sent_count < 700);
      if (sent_count == 300 || sent_count == 850)
         squeeze = 1'b1;
   endtask

   // Stop offering and let the table go quiet before touching registers.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic conn_request_type command(logic [1:0] action, logic [31:0] now_ms,
                                                logic [4:0] index);
      conn_request_type r;
      r.action       = action;
      r.source_ip    = $urandom;
      r.source_port  = 16'($urandom_range(65535));
      r.qport        = 16'($urandom_range(65535));
      r.packet_seq   = 31'($urandom);
      r.packet_rel   = 1'($urandom_range(1));
      r.now_ms       = now_ms;
      r.remove_index = index;
      return r;
   endfunction

   function automatic conn_request_type packet(logic [31:0] ip, logic [15:0] qport,
                                               logic [15:0] port, logic [30:0] seq,
                                               logic rel, logic [31:0] now_ms);
      conn_request_type r;
      r             = command(ctsf_pkg::ACT_PACKET, now_ms, 5'($urandom_range(31)));
      r.source_ip   = ip;
      r.qport       = qport;
      r.source_port = port;
      r.packet_seq  = seq;
      r.packet_rel  = rel;
      return r;
   endfunction

   function automatic conn_request_type make_random_request(int max_step, int key_span);
      conn_request_type r;
      int               roll;
      int               k;
      int               count;
      logic [31:0]      now_ms;
      if ($urandom_range(99) >= 30)
         wall_ms = wall_ms + $urandom_range(max_step);
      now_ms = ($urandom_range(99) < 3) ? $urandom : wall_ms;
      roll   = $urandom_range(99);
      count  = sb.used;
      if (roll < 70) begin
         k = $urandom_range(key_span - 1);
         // drop back once the key nears the top of the sequence space
         if (pool_seq[k] > 31'h7fff_0000)
            pool_seq[k] = '0;
         r = packet(pool_ip[k], pool_qport[k], 16'($urandom_range(65535)), '0,
                    1'($urandom_range(1)), now_ms);
         roll = $urandom_range(99);
         if (roll < 82)
            r.packet_seq = pool_seq[k] + 31'($urandom_range(1, 3));
         else if (roll < 96)
            r.packet_seq = pool_seq[k] - 31'($urandom_range(0, 2));
         else
            r.packet_seq = 31'($urandom);
         if (r.packet_seq > pool_seq[k])
            pool_seq[k] = r.packet_seq;
      end else if (roll < 78) begin
         r = command(ctsf_pkg::ACT_PACKET, now_ms, 5'($urandom_range(31)));
      end else if (roll < 88) begin
         r = command(ctsf_pkg::ACT_FIND, now_ms, 5'($urandom_range(31)));
      end else if (roll < 98) begin
         if (count > 0 && $urandom_range(99) < 70)
            r = command(ctsf_pkg::ACT_REMOVE, now_ms, 5'($urandom_range(count - 1)));
         else
            r = command(ctsf_pkg::ACT_REMOVE, now_ms, 5'($urandom_range(31)));
      end else begin
         r = command(ACT_UNKNOWN, now_ms, 5'($urandom_range(31)));
      end
      return r;
   endfunction

   task automatic run_phase(input logic [5:0] max_clients, input logic [31:0] timeout_ms,
                            input int items, input int max_step, input int key_span);
      logic [31:0] high_bits;
      drain();
      high_bits = $urandom;
      write_register(ctsf_pkg::REG_MAX_CLIENTS, {high_bits[31:6], max_clients});
      write_register(ctsf_pkg::REG_TIMEOUT_MS, timeout_ms);
      repeat (items) send_request(make_random_request(max_step, key_span));
   endtask

   initial begin
      reset            = 1'b1;
      csr_valid        = 1'b0;
      csr_index        = 1'b0;
      csr_data         = '0;
      req_valid        = 1'b0;
      req_action       = ctsf_pkg::ACT_PACKET;
      req_source_ip    = '0;
      req_source_port  = '0;
      req_qport        = '0;
      req_packet_seq   = '0;
      req_packet_rel   = 1'b0;
      req_now_ms       = '0;
      req_remove_index = '0;
      wall_ms          = 32'hFFFF_F000;
      for (int i = 0; i < POOL_KEYS; i++) begin
         pool_ip[i]    = $urandom;
         pool_qport[i] = 16'($urandom_range(65535));
         pool_seq[i]   = '0;
      end
      // keys that differ in only one half of the key, and all-zero and all-one keys
      pool_ip[1]    = pool_ip[0];
      pool_qport[1] = pool_qport[0] ^ 16'h0001;
      pool_qport[2] = pool_qport[0];
      pool_ip[2]    = pool_ip[0] ^ 32'h8000_0000;
      pool_ip[3]    = '0;
      pool_qport[3] = '0;
      pool_ip[4]    = '1;
      pool_qport[4] = '1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, then a first packet with sequence zero
      send_request(command(ctsf_pkg::ACT_FIND, 32'd0, 5'd0));
      send_request(command(ctsf_pkg::ACT_REMOVE, 32'd0, 5'd0));
      send_request(command(ACT_UNKNOWN, 32'hFFFF_FFFF, 5'd31));
      send_request(packet(32'h0, 16'h0, 16'h1234, 31'd0, 1'b0, 32'd0));
      send_request(packet(32'h0, 16'h0, 16'hFFFF, 31'd1, 1'b1, 32'd5));
      send_request(packet(32'h0, 16'h0, 16'h0000, 31'd1, 1'b0, 32'd6));
      send_request(packet(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 1'b1, 32'd10));
      send_request(packet(32'h0, 16'hFFFF, 16'h0000, 31'd5, 1'b0, 32'd10));
      send_request(packet(32'h0, 16'h0, 16'h5555, 31'd2, 1'b1, 32'd20));
      // age exactly at the timeout still passes, one past it does not
      send_request(packet(32'h0, 16'hFFFF, 16'hAAAA, 31'd6, 1'b1, 32'd10010));
      send_request(packet(32'h0, 16'h0, 16'h0000, 31'd3, 1'b0, 32'd10021));
      send_request(command(ctsf_pkg::ACT_FIND, 32'd10021, 5'd0));
      send_request(command(ctsf_pkg::ACT_FIND, 32'hFFFF_FFFF, 5'd0));
      send_request(command(ctsf_pkg::ACT_REMOVE, 32'd0, 5'd0));
      send_request(command(ctsf_pkg::ACT_REMOVE, 32'd0, 5'd2));
      send_request(command(ctsf_pkg::ACT_REMOVE, 32'd0, 5'd31));
      send_request(packet(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 31'h7FFF_FFFF, 1'b0, 32'd20));
      drain();
      write_register(ctsf_pkg::REG_MAX_CLIENTS, 32'd2);
      send_request(packet(32'h1, 16'h1, 16'h0101, 31'd1, 1'b1, 32'd30));
      send_request(packet(32'h0, 16'hFFFF, 16'h0000, 31'd7, 1'b1, 32'd30));
      drain();
      write_register(ctsf_pkg::REG_MAX_CLIENTS, 32'd3);
      send_request(packet(32'h1, 16'h1, 16'h0101, 31'd1, 1'b1, 32'd31));

      run_phase(6'd32, 32'd10000, 260, 20, POOL_KEYS);
      run_phase(6'd0, 32'd10000, 80, 20, POOL_KEYS);
      run_phase(6'd1, 32'd0, 100, 2, 4);
      run_phase(6'd63, 32'hFFFF_FFFF, 200, 3000, POOL_KEYS);
      run_phase(6'd5, 32'd60, 160, 20, 8);
      run_phase(6'd33, $urandom, 100, 200, POOL_KEYS);
      run_phase(6'd32, 32'd10000, 200, 20, POOL_KEYS);

      drain();
      if (sb.failures == 0 && sb.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ connection_table_sequence_filter_core.f @@
design/ctsf_pkg.sv
design/ctsf_entry_ram.sv
design/connection_table_sequence_filter_core.sv
tb/sv/testbench.sv
